@@ design/kmm_pkg.sv @@
// kmm_pkg: shared types and constants for the keyword match and mask block
// used by kmm_kw_cell, kmm_win_cell and keyword_match_and_mask
package kmm_pkg;

    localparam int CODE_W  = 21;
    localparam int COUNT_W = 16;

    localparam logic [CODE_W-1:0]  STAR_CODE = 21'd42;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef logic [CODE_W-1:0] code_t;

    // control of one window cell
    typedef struct packed {
        logic shift;
        logic set_star;
    } win_ctrl_t;

    // control of one keyword cell
    typedef struct packed {
        logic active;
        logic wr;
    } kw_ctrl_t;

endpackage

@@ design/kmm_win_cell.sv @@
// kmm_win_cell: one stage of the text window shift chain (character and star flag)
// depends on kmm_pkg
module kmm_win_cell
    import kmm_pkg::*;
(
    input  logic      clk,
    input  win_ctrl_t ctrl,
    input  code_t     in_char,
    input  logic      in_star,
    output code_t     out_char,
    output logic      out_star
);

    code_t char_reg;
    logic  star_reg;

    // shift from the younger neighbor, or mark for masking
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            char_reg <= in_char;
            star_reg <= in_star;
        end
        else if (ctrl.set_star)
        begin
            star_reg <= 1'b1;
        end
    end

    assign out_char = char_reg;
    assign out_star = star_reg;

endmodule

@@ design/kmm_kw_cell.sv @@
// kmm_kw_cell: one stored keyword, held newest character first, compared with the window
// depends on kmm_pkg
module kmm_kw_cell
    import kmm_pkg::*;
#(
    parameter int MAX_LEN = 8,
    parameter int LW      = $clog2(MAX_LEN + 1)
)
(
    input  logic                           clk,
    input  kw_ctrl_t                       ctrl,
    input  logic [MAX_LEN-1:0][CODE_W-1:0] wr_chars,
    input  logic [LW-1:0]                  wr_len,
    input  logic [MAX_LEN-1:0][CODE_W-1:0] hist,
    output logic [MAX_LEN-1:0]             hit_len,
    output logic                           dup
);

    logic [MAX_LEN-1:0][CODE_W-1:0] chars_reg;
    logic [LW-1:0]                  len_reg;
    logic                           hit_all;
    logic                           dup_all;

    // keyword storage
    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            chars_reg <= wr_chars;
            len_reg   <= wr_len;
        end
    end

    // compare within the stored length against window and load buffer
    always_comb
    begin
        hit_all = ctrl.active;
        dup_all = ctrl.active && (len_reg == wr_len);
        for (int m = 0; m < MAX_LEN; m++)
        begin
            if (LW'(m) < len_reg)
            begin
                if (chars_reg[m] != hist[m])
                    hit_all = 1'b0;
                if (chars_reg[m] != wr_chars[m])
                    dup_all = 1'b0;
            end
        end
        for (int l = 0; l < MAX_LEN; l++)
            hit_len[l] = hit_all && (len_reg == LW'(l + 1));
    end

    assign dup = dup_all;

endmodule

@@ design/keyword_match_and_mask.sv @@
// keyword_match_and_mask: top level, keyword loading, longest match and masking control
// depends on kmm_pkg, kmm_kw_cell, kmm_win_cell
//
// channel | direction | tdata (low bit up)                     | tuser  | tlast
// s_*     | in        | code[20:0], zero pad to 24             | func   | last
// m_*     | out       | out_code[20:0], match_count[36:21], pad | masked | end_of_text
//
// a keyword word is taken in idle; the final word of a keyword adds a duplicate check
// state; a text word goes through window shift, parallel compare and mask update, an
// output state when it pushes out the oldest window word, and a flush of each word
// on the last text word; the output register stalls the sequencer when m_tready is low
// reset clears all counters and control; keyword and window contents need no reset
module keyword_match_and_mask
    import kmm_pkg::*;
#(
    parameter int MAX_KEYWORDS = 16,
    parameter int MAX_LEN      = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // code
    input  logic        s_tuser,   // func
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_code, match_count
    output logic        m_tuser,   // masked
    output logic        m_tlast    // end_of_text
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int TW = $clog2(MAX_KEYWORDS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_KCHK  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [MAX_LEN-1:0][CODE_W-1:0] buf_reg, buf_next;
    logic [LW-1:0] ll_reg, ll_next;
    logic ovf_reg, ovf_next;
    logic [TW-1:0] total_reg, total_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [LW-1:0] unc_reg, unc_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0] matches_reg, matches_next;
    logic last_reg, last_next;
    logic [MAX_LEN-1:0] hitv_reg, hitv_next;
    logic ov_reg, ov_next;
    code_t oc_reg, oc_next;
    logic om_reg, om_next;
    logic oe_reg, oe_next;
    logic [COUNT_W-1:0] on_reg, on_next;

    logic in_acc;
    logic out_free;
    logic kw_write;
    logic shift_win;
    logic any_dup;
    logic [LW-1:0] best;
    logic [IW-1:0] rd_idx;
    logic [MAX_LEN-1:0] set_star;
    logic [MAX_LEN-1:0][CODE_W-1:0] hist;
    logic [MAX_LEN-1:0] star;
    logic [MAX_KEYWORDS-1:0][MAX_LEN-1:0] hit_len;
    logic [MAX_KEYWORDS-1:0] dup;
    code_t in_code;

    assign in_code  = s_tdata[CODE_W-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !ov_reg || m_tready;
    assign any_dup  = |dup;

    // keyword cells
    for (genvar i = 0; i < MAX_KEYWORDS; i++)
    begin : g_kw
        kw_ctrl_t kc;
        assign kc.active = (TW'(i) < total_reg);
        assign kc.wr     = kw_write && (total_reg == TW'(i));
        kmm_kw_cell #(.MAX_LEN(MAX_LEN), .LW(LW)) u_cell
        (
            .clk      (clk),
            .ctrl     (kc),
            .wr_chars (buf_reg),
            .wr_len   (ll_reg),
            .hist     (hist),
            .hit_len  (hit_len[i]),
            .dup      (dup[i])
        );
    end

    // window chain, cell 0 holds the newest word
    for (genvar k = 0; k < MAX_LEN; k++)
    begin : g_win
        win_ctrl_t wc;
        code_t     cin;
        logic      sin;
        assign wc.shift    = shift_win;
        assign wc.set_star = set_star[k];
        if (k == 0)
        begin : g_head
            assign cin = in_code;
            assign sin = 1'b0;
        end
        else
        begin : g_body
            assign cin = hist[k-1];
            assign sin = star[k-1];
        end
        kmm_win_cell u_cell
        (
            .clk      (clk),
            .ctrl     (wc),
            .in_char  (cin),
            .in_star  (sin),
            .out_char (hist[k]),
            .out_star (star[k])
        );
    end

    // longest hit length and masked span
    always_comb
    begin
        best = '0;
        for (int l = 1; l <= MAX_LEN; l++)
            if (hitv_reg[l-1])
                best = LW'(l);
        for (int k = 0; k < MAX_LEN; k++)
            set_star[k] = (state_reg == S_UPD) && (LW'(k) < best) && (LW'(k) < unc_reg);
    end

    assign rd_idx = (state_reg == S_OUT) ? IW'(MAX_LEN - 1) : IW'(cnt_reg - LW'(1));

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        buf_next     = buf_reg;
        ll_next      = ll_reg;
        ovf_next     = ovf_reg;
        total_next   = total_reg;
        fill_next    = fill_reg;
        unc_next     = unc_reg;
        cnt_next     = cnt_reg;
        matches_next = matches_reg;
        last_next    = last_reg;
        hitv_next    = hitv_reg;
        ov_next      = ov_reg && !m_tready;
        oc_next      = oc_reg;
        om_next      = om_reg;
        oe_next      = oe_reg;
        on_next      = on_reg;
        kw_write     = 1'b0;
        shift_win    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && !s_tuser)
                begin
                    if ((total_reg >= TW'(MAX_KEYWORDS)) || (ll_reg >= LW'(MAX_LEN)))
                        ovf_next = 1'b1;
                    else
                    begin
                        buf_next[0] = in_code;
                        for (int m = 1; m < MAX_LEN; m++)
                            buf_next[m] = buf_reg[m-1];
                        ll_next = ll_reg + LW'(1);
                    end
                    if (s_tlast)
                        state_next = S_KCHK;
                end
                else if (in_acc)
                begin
                    shift_win  = 1'b1;
                    fill_next  = fill_reg + LW'(1);
                    unc_next   = (unc_reg >= LW'(MAX_LEN)) ? unc_reg : unc_reg + LW'(1);
                    last_next  = s_tlast;
                    state_next = S_CMP;
                end
            end
            S_KCHK:
            begin
                kw_write = !ovf_reg && (ll_reg != '0) &&
                           (total_reg < TW'(MAX_KEYWORDS)) && !any_dup;
                if (kw_write)
                    total_next = total_reg + TW'(1);
                ll_next    = '0;
                ovf_next   = 1'b0;
                state_next = S_IDLE;
            end
            S_CMP:
            begin
                for (int l = 0; l < MAX_LEN; l++)
                begin
                    hitv_next[l] = 1'b0;
                    for (int i = 0; i < MAX_KEYWORDS; i++)
                        hitv_next[l] = hitv_next[l] | hit_len[i][l];
                    hitv_next[l] = hitv_next[l] && (LW'(l + 1) <= fill_reg);
                end
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (best != '0)
                begin
                    unc_next = '0;
                    if (matches_reg != COUNT_MAX)
                        matches_next = matches_reg + COUNT_W'(1);
                end
                if (last_reg)
                begin
                    cnt_next   = fill_reg;
                    state_next = S_FLUSH;
                end
                else if (fill_reg >= LW'(MAX_LEN))
                    state_next = S_OUT;
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oc_next    = star[rd_idx] ? STAR_CODE : hist[rd_idx];
                    om_next    = star[rd_idx];
                    oe_next    = 1'b0;
                    on_next    = '0;
                    fill_next  = fill_reg - LW'(1);
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    oc_next  = star[rd_idx] ? STAR_CODE : hist[rd_idx];
                    om_next  = star[rd_idx];
                    oe_next  = (cnt_reg == LW'(1));
                    on_next  = (cnt_reg == LW'(1)) ? matches_reg : '0;
                    cnt_next = cnt_reg - LW'(1);
                    if (cnt_reg == LW'(1))
                    begin
                        fill_next    = '0;
                        unc_next     = '0;
                        matches_next = '0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ll_reg      <= '0;
            ovf_reg     <= 1'b0;
            total_reg   <= '0;
            fill_reg    <= '0;
            unc_reg     <= '0;
            cnt_reg     <= '0;
            matches_reg <= '0;
            last_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ll_reg      <= ll_next;
            ovf_reg     <= ovf_next;
            total_reg   <= total_next;
            fill_reg    <= fill_next;
            unc_reg     <= unc_next;
            cnt_reg     <= cnt_next;
            matches_reg <= matches_next;
            last_reg    <= last_next;
            ov_reg      <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        hitv_reg <= hitv_next;
        oc_reg   <= oc_next;
        om_reg   <= om_next;
        oe_reg   <= oe_next;
        on_reg   <= on_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {3'b000, on_reg, oc_reg};
    assign m_tuser  = om_reg;
    assign m_tlast  = oe_reg;

endmodule
